// ===== rtl/core/slfr_pkg.sv =====
// ----------------------------------------------------------------------------
// slfr_pkg
// Shared constants and types for the subtractive lagged Fibonacci generator.
// ----------------------------------------------------------------------------
package slfr_pkg;

  localparam int LONG_LAG   = 55;
  localparam int TAP_OFFSET = 31;
  localparam int WORD_W     = 31;
  localparam int CNT_W      = $clog2(LONG_LAG);

  // Minimal-standard refill generator: g = 48271 * g mod (2^31 - 1).
  localparam int MS_MULT = 48271;
  localparam int MULT_W  = $clog2(MS_MULT + 1);
  localparam int PROD_W  = WORD_W + MULT_W;
  localparam logic [WORD_W-1:0] MS_MOD = {WORD_W{1'b1}};

  typedef enum logic [1:0] {
    ST_RUN,
    ST_MUL,
    ST_FOLD
  } slfr_state_t;

  // Shift control for the chain of lag cells.
  typedef struct packed {
    logic              shift;
    logic [WORD_W-1:0] word;
  } chain_ctl_t;

  // Control for the refill generator.
  typedef struct packed {
    logic load;
    logic mul;
    logic fold;
  } fill_ctl_t;

endpackage

// ===== rtl/core/slfr_cell.sv =====
// ----------------------------------------------------------------------------
// slfr_cell
// One lag entry: a word register that takes its neighbor's word on shift.
// ----------------------------------------------------------------------------
module slfr_cell (
  input  logic                       clk,
  input  logic                       shift,
  input  logic [slfr_pkg::WORD_W-1:0] d,
  output logic [slfr_pkg::WORD_W-1:0] q
);
  import slfr_pkg::*;

  always_ff @(posedge clk) begin
    if (shift) begin
      q <= d;
    end
  end

endmodule

// ===== rtl/core/slfr_chain.sv =====
// ----------------------------------------------------------------------------
// slfr_chain
// Row of lag cells ordered by age; cell 0 holds the oldest word.
// ----------------------------------------------------------------------------
module slfr_chain (
  input  logic                        clk,
  input  slfr_pkg::chain_ctl_t        ctl,
  output logic [slfr_pkg::WORD_W-1:0] oldest,
  output logic [slfr_pkg::WORD_W-1:0] tap
);
  import slfr_pkg::*;

  logic [WORD_W-1:0] cell_q [LONG_LAG];
  logic [WORD_W-1:0] cell_d [LONG_LAG];

  for (genvar i = 0; i < LONG_LAG; i++) begin : g_cell
    // The newest word enters at the young end; the rest move one step older.
    if (i == LONG_LAG - 1) begin : g_young
      assign cell_d[i] = ctl.word;
    end else begin : g_mid
      assign cell_d[i] = cell_q[i+1];
    end

    slfr_cell u_cell (
      .clk   (clk),
      .shift (ctl.shift),
      .d     (cell_d[i]),
      .q     (cell_q[i])
    );
  end

  assign oldest = cell_q[0];
  assign tap    = cell_q[TAP_OFFSET];

endmodule

// ===== rtl/core/slfr_fill.sv =====
// ----------------------------------------------------------------------------
// slfr_fill
// Minimal-standard generator used to refill the lag cells: multiply, then fold.
// ----------------------------------------------------------------------------
module slfr_fill (
  input  logic                        clk,
  input  slfr_pkg::fill_ctl_t         ctl,
  input  logic [slfr_pkg::WORD_W-1:0] seed,
  output logic [slfr_pkg::WORD_W-1:0] word
);
  import slfr_pkg::*;

  logic [WORD_W-1:0] gen;
  logic [PROD_W-1:0] prod;
  logic [WORD_W:0]   fsum;
  logic [WORD_W-1:0] folded;

  // 2^31 is 1 mod 2^31-1, so the high part folds onto the low part. The sum
  // stays below twice the modulus, so one conditional subtract finishes it.
  always_comb begin
    fsum = {1'b0, prod[WORD_W-1:0]} + (WORD_W+1)'(prod[PROD_W-1:WORD_W]);
    if (fsum >= {1'b0, MS_MOD}) begin
      folded = WORD_W'(fsum - {1'b0, MS_MOD});
    end else begin
      folded = fsum[WORD_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.load) begin
      gen <= seed;
    end else if (ctl.fold) begin
      gen <= folded;
    end
    if (ctl.mul) begin
      prod <= PROD_W'(gen) * PROD_W'(MS_MULT);
    end
  end

  assign word = folded;

endmodule

// ===== rtl/core/subtractive_lagged_fibonacci_rng_core.sv =====
// ----------------------------------------------------------------------------
// subtractive_lagged_fibonacci_rng_core
// Subtractive lagged Fibonacci generator, lags 55 and 24, 31-bit words.
// ----------------------------------------------------------------------------
//  channel  | direction | handshake          | payload
//  ---------+-----------+--------------------+--------------------
//  in       | input     | in_valid/in_stall  | reseed
//  out      | output    | out_valid/out_stall| random_value
//  config   | input     | write_enable       | write_data (seed)
//
// A word without reseed is accepted each cycle unless in_stall is high, and
// shows at the output in the next cycle. A refill (first word after reset, or
// reseed) runs the minimal-standard generator once per entry, through a
// multiply state and a fold state. Reset clears control state; the lag cells
// are undefined until the first refill. The output register lets a new word in
// while holding the previous one only if that one is taken in the same cycle.
// ----------------------------------------------------------------------------
module subtractive_lagged_fibonacci_rng_core (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic                        reseed,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic [slfr_pkg::WORD_W-1:0] random_value,
  input  logic                        write_enable,
  input  logic [slfr_pkg::WORD_W-1:0] write_data
);
  import slfr_pkg::*;

  slfr_state_t       state;
  slfr_state_t       state_next;
  logic [WORD_W-1:0] seed_value;
  logic [CNT_W-1:0]  fill_count;
  logic              filled;
  logic              pending;

  logic              accept;
  logic              out_free;
  logic              need_fill;
  logic              produce;
  logic              start_fill;
  logic              fill_last;
  logic [WORD_W-1:0] oldest;
  logic [WORD_W-1:0] tap;
  logic [WORD_W-1:0] new_word;
  logic [WORD_W-1:0] fill_word;
  chain_ctl_t        chain_ctl;
  fill_ctl_t         fill_ctl;

  assign accept    = in_valid && !in_stall;
  assign out_free  = !out_valid || !out_stall;
  assign need_fill = reseed || !filled;
  assign new_word  = tap - oldest;
  assign fill_last = (fill_count == CNT_W'(LONG_LAG - 1));

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_RUN;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    in_stall   = 1'b1;
    produce    = 1'b0;
    start_fill = 1'b0;
    case (state)
      ST_RUN: begin
        in_stall = pending || !out_free;
        // A word held back by a refill goes out as soon as the output is free.
        produce    = out_free && (pending || (accept && !need_fill));
        start_fill = accept && need_fill;
        if (start_fill) begin
          state_next = ST_MUL;
        end
      end
      ST_MUL: begin
        state_next = ST_FOLD;
      end
      ST_FOLD: begin
        state_next = fill_last ? ST_RUN : ST_MUL;
      end
      default: begin
        state_next = ST_RUN;
      end
    endcase
  end

  always_comb begin
    chain_ctl.shift = produce || (state == ST_FOLD);
    chain_ctl.word  = (state == ST_FOLD) ? fill_word : new_word;
    fill_ctl.load   = start_fill;
    fill_ctl.mul    = (state == ST_MUL);
    fill_ctl.fold   = (state == ST_FOLD);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      seed_value <= WORD_W'(1);
      fill_count <= '0;
      filled     <= 1'b0;
      pending    <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      if (write_enable) begin
        seed_value <= write_data;
      end
      if (start_fill) begin
        fill_count <= '0;
        pending    <= 1'b1;
      end else if (state == ST_FOLD) begin
        fill_count <= fill_count + CNT_W'(1);
        if (fill_last) begin
          filled <= 1'b1;
        end
      end else if (produce) begin
        pending <= 1'b0;
      end
      if (produce) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (produce) begin
      random_value <= new_word;
    end
  end

  slfr_chain u_chain (
    .clk    (clk),
    .ctl    (chain_ctl),
    .oldest (oldest),
    .tap    (tap)
  );

  slfr_fill u_fill (
    .clk  (clk),
    .ctl  (fill_ctl),
    .seed (seed_value),
    .word (fill_word)
  );

endmodule

// ===== rtl/core/slfr_checker.sv =====
// ----------------------------------------------------------------------------
// slfr_checker
// Port-level checks on the generator core, attached by bind.
// ----------------------------------------------------------------------------
module slfr_checker (
  input logic                        clk,
  input logic                        rst,
  input logic                        in_valid,
  input logic                        in_stall,
  input logic                        reseed,
  input logic                        out_valid,
  input logic                        out_stall,
  input logic [slfr_pkg::WORD_W-1:0] random_value,
  input logic                        write_enable
);
  import slfr_pkg::*;

  // A stalled word holds its value.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(random_value))
    else $error("stalled output word changed");

  a_reset_empty: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("output valid right after reset");

  // A reseed starts a refill, so the input side must stall next cycle.
  a_reseed_stall: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall && reseed |=> in_stall)
    else $error("input not stalled during refill");

  // A refill must run first, so no word can follow a reseed directly.
  a_reseed_latency: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall && reseed && !out_valid |=> !out_valid)
    else $error("word produced before refill finished");

  // The seed is only written while no word is offered or waiting at the output.
  a_cfg_idle: assert property (@(posedge clk) disable iff (rst)
    write_enable |-> !in_valid && !out_valid)
    else $error("seed written while words were in flight");

endmodule

bind subtractive_lagged_fibonacci_rng_core slfr_checker u_slfr_checker (
  .clk          (clk),
  .rst          (rst),
  .in_valid     (in_valid),
  .in_stall     (in_stall),
  .reseed       (reseed),
  .out_valid    (out_valid),
  .out_stall    (out_stall),
  .random_value (random_value),
  .write_enable (write_enable)
);

// ===== tb/sv/slfr_checker.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// slfr_tb_checker
// Watches the input, output and seed ports of the lagged Fibonacci generator,
// predicts every output word from its own copy of the lag cells and the seed,
// and compares each accepted output word with the oldest prediction.
// ----------------------------------------------------------------------------
module slfr_tb_checker (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_valid,
  input  logic                        in_stall,
  input  logic                        reseed,
  input  logic                        out_valid,
  input  logic                        out_stall,
  input  logic [slfr_pkg::WORD_W-1:0] random_value,
  input  logic                        write_enable,
  input  logic [slfr_pkg::WORD_W-1:0] write_data,
  output int                          fail_count,
  output int                          pending
);
  import slfr_pkg::*;

  logic [WORD_W-1:0] seed_reg;
  logic [WORD_W-1:0] lag_cells [LONG_LAG];
  int                ring_ptr;
  logic              filled;
  logic [WORD_W-1:0] expected_values [$];

  function automatic logic [WORD_W-1:0] ms_step(input logic [WORD_W-1:0] g);
    logic [63:0] prod;
    logic [63:0] rem;
    prod = {33'd0, g} * 64'(MS_MULT);
    rem  = prod % {33'd0, MS_MOD};
    return rem[WORD_W-1:0];
  endfunction

  function automatic void refill_lag_cells();
    logic [WORD_W-1:0] g;
    g = seed_reg;
    for (int k = 0; k < LONG_LAG; k++) begin
      g = ms_step(g);
      lag_cells[k] = g;
    end
    ring_ptr = 0;
    filled   = 1'b1;
  endfunction

  // Subtraction at 31 bits gives the mod 2^31 wrap for free.
  function automatic logic [WORD_W-1:0] next_random(input logic refill_now);
    int                tap;
    logic [WORD_W-1:0] v;
    if (refill_now || !filled) refill_lag_cells();
    tap = (ring_ptr + TAP_OFFSET) % LONG_LAG;
    v = lag_cells[tap] - lag_cells[ring_ptr];
    lag_cells[ring_ptr] = v;
    ring_ptr = (ring_ptr + 1) % LONG_LAG;
    return v;
  endfunction

  task automatic report_mismatch(input string what, input logic [WORD_W-1:0] got,
                                 input logic [WORD_W-1:0] want);
    $display("%0t ns: %s: got %0d, expected %0d", $realtime, what, got, want);
    fail_count++;
  endtask

  always @(posedge clk) begin
    logic [WORD_W-1:0] want;
    if (rst) begin
      seed_reg = 31'd1;
      filled   = 1'b0;
      ring_ptr = 0;
      expected_values.delete();
    end else begin
      if (write_enable) seed_reg = write_data;
      if (in_valid && !in_stall) expected_values.push_back(next_random(reseed));
      if (out_valid && !out_stall) begin
        if (expected_values.size() == 0) begin
          report_mismatch("output word with none expected", random_value, '0);
        end else begin
          want = expected_values.pop_front();
          if (random_value !== want) report_mismatch("random_value", random_value, want);
        end
      end
    end
    pending <= expected_values.size();
  end

endmodule

// ===== tb/sv/tb_top.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Drives request words into the lagged Fibonacci generator in random bursts,
// stalls its output on a pattern of its own, and changes the seed between
// phases. A directed opening covers the first refill, reseeds, the extreme
// seeds and the all-zero ring; random phases with rare reseeds then run the ring
// on. The checker beside the block predicts and compares.
// ----------------------------------------------------------------------------
module tb_top;
  import slfr_pkg::*;

  localparam int LONG_HOLD   = 250;
  localparam int QUIET_LIMIT = 3000;
  localparam int TAIL_CYCLES = 20;

  logic              clk = 1'b0;
  logic              rst = 1'b1;
  logic              in_valid = 1'b0;
  logic              in_stall;
  logic              reseed = 1'b0;
  logic              out_valid;
  logic              out_stall = 1'b0;
  logic [WORD_W-1:0] random_value;
  logic              write_enable = 1'b0;
  logic [WORD_W-1:0] write_data = '0;

  int fail_count;
  int pending;
  int hold_requests = 0;
  int holds_done = 0;
  int quiet_cycles = 0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  subtractive_lagged_fibonacci_rng_core u_dut (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .reseed       (reseed),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .random_value (random_value),
    .write_enable (write_enable),
    .write_data   (write_data)
  );

  slfr_tb_checker u_checker (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .reseed       (reseed),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .random_value (random_value),
    .write_enable (write_enable),
    .write_data   (write_data),
    .fail_count   (fail_count),
    .pending      (pending)
  );

  // Holds the word until the block takes it.
  task automatic send_word(input logic rs);
    in_valid <= 1'b1;
    reseed   <= rs;
    do @(posedge clk); while (in_stall);
  endtask

  task automatic wait_idle();
    in_valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
  endtask

  task automatic write_seed(input logic [WORD_W-1:0] value);
    wait_idle();
    write_enable <= 1'b1;
    write_data   <= value;
    @(posedge clk);
    write_enable <= 1'b0;
  endtask

  task automatic directed_words(input int n_words, input logic [15:0] reseed_bits);
    for (int i = 0; i < n_words; i++) send_word(reseed_bits[i]);
  endtask

  task automatic run_words(input int n_words, input int reseed_pct, input logic first_reseed);
    int   sent;
    int   burst;
    int   gap;
    logic rs;
    sent = 0;
    while (sent < n_words) begin
      burst = ($urandom_range(0, 4) == 0) ? $urandom_range(20, 40) : $urandom_range(1, 12);
      while (burst > 0 && sent < n_words) begin
        rs = (sent == 0 && first_reseed) || ($urandom_range(0, 99) < reseed_pct);
        send_word(rs);
        sent++;
        burst--;
      end
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap > 0) begin
        in_valid <= 1'b0;
        reseed   <= 1'($urandom_range(0, 1));
        repeat (gap) @(posedge clk);
      end
    end
  endtask

  // Receiver: random stall stretches, plus a long hold-off when asked for.
  initial begin
    int stretch;
    int mode;
    forever begin
      if (hold_requests != holds_done) begin
        out_stall <= 1'b1;
        repeat (LONG_HOLD) @(posedge clk);
        holds_done++;
      end else begin
        mode    = $urandom_range(0, 2);
        stretch = $urandom_range(5, 60);
        repeat (stretch) begin
          case (mode)
            0: begin
              out_stall <= 1'b0;
            end
            1: begin
              out_stall <= ($urandom_range(0, 3) == 0);
            end
            default: begin
              out_stall <= ($urandom_range(0, 3) != 0);
            end
          endcase
          @(posedge clk);
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall) || write_enable) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    logic [WORD_W-1:0] seed;
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // First word refills from the reset seed even without reseed.
    directed_words(4, 16'b0100);
    write_seed(31'd2147483646);
    directed_words(3, 16'b001);
    // Seeds that collapse the refill generator give an all-zero ring.
    write_seed(31'd0);
    directed_words(3, 16'b001);
    write_seed(31'h7FFFFFFF);
    directed_words(2, 16'b01);
    // A new seed only matters at the next refill: two more zeros first.
    write_seed(31'd12345);
    directed_words(4, 16'b0100);

    for (int p = 0; p < 7; p++) begin
      case ($urandom_range(0, 5))
        0: seed = 31'd1;
        1: seed = 31'd2147483646;
        2: seed = WORD_W'($urandom);
        default: seed = WORD_W'($urandom_range(1, 2147483646));
      endcase
      write_seed(seed);
      if (p == 1 || p == 4) hold_requests++;
      run_words($urandom_range(50, 75), 3, 1'($urandom_range(0, 1)));
    end

    wait_idle();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (fail_count == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
rtl/core/slfr_pkg.sv
rtl/core/slfr_cell.sv
rtl/core/slfr_chain.sv
rtl/core/slfr_fill.sv
rtl/core/subtractive_lagged_fibonacci_rng_core.sv
rtl/core/slfr_checker.sv
tb/sv/slfr_checker.sv
tb/sv/tb_top.sv
